// ----- rtl/bbcr_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the buffer pool.
package bbcr_pkg;

  localparam int SLOTS            = 64;
  localparam int SLOT_BITS        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TABLE_ID_BITS    = 16;
  localparam int BLOCK_INDEX_BITS = 24;
  localparam int TAG_BITS         = TABLE_ID_BITS + BLOCK_INDEX_BITS;
  localparam int OUT_SLOT_BITS    = 6;
  localparam int OP_BITS          = 2;
  localparam int FILL_BITS        = 2;

  localparam logic [OP_BITS-1:0] OP_GET   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_DROP  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  localparam logic [FILL_BITS-1:0] FILL_NONE = 2'd0;
  localparam logic [FILL_BITS-1:0] FILL_READ = 2'd1;
  localparam logic [FILL_BITS-1:0] FILL_ZERO = 2'd2;

  typedef logic [SLOTS-1:0]     slot_vec_t;
  typedef logic [SLOT_BITS-1:0] slot_idx_t;

  typedef struct packed {
    logic load_req;     // capture request fields
    logic lookup;       // register tag compare vectors
    logic select;       // encode hit / victim, start tag read
    logic get_commit;   // deliver get result, update slot state
    logic zero_commit;  // deliver empty result, apply drop
    logic clr_pick;     // pick next valid slot to write back
    logic clr_commit;   // deliver one clear write-back
  } bbcr_cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] req_op;
    logic               any_valid;
    logic               clr_last;
    logic               out_free;
  } bbcr_sts_t;

endpackage

// ----- rtl/bbcr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bbcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bbcr_datapath.sv -----
// Slot state, tag compare, victim selection, write-back tag store and result register.
module bbcr_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bbcr_pkg::bbcr_cmd_t                    cmd,
  output bbcr_pkg::bbcr_sts_t                    sts,
  input  logic [bbcr_pkg::OP_BITS-1:0]           in_operation,
  input  logic [bbcr_pkg::TABLE_ID_BITS-1:0]     in_table_id,
  input  logic [bbcr_pkg::BLOCK_INDEX_BITS-1:0]  in_block_index,
  input  logic                                   in_fresh_block,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic                                   out_hit,
  output logic [bbcr_pkg::OUT_SLOT_BITS-1:0]     out_slot,
  output logic                                   out_writeback_valid,
  output logic [bbcr_pkg::TABLE_ID_BITS-1:0]     out_writeback_table,
  output logic [bbcr_pkg::BLOCK_INDEX_BITS-1:0]  out_writeback_block,
  output logic [bbcr_pkg::FILL_BITS-1:0]         out_fill_action,
  output logic                                   out_last
);

  function automatic bbcr_pkg::slot_vec_t lowest_one(input bbcr_pkg::slot_vec_t v);
    return v & (~v + bbcr_pkg::slot_vec_t'(1));
  endfunction

  function automatic bbcr_pkg::slot_idx_t onehot_index(input bbcr_pkg::slot_vec_t v);
    bbcr_pkg::slot_idx_t idx;
    idx = '0;
    for (int i = 0; i < bbcr_pkg::SLOTS; i++) begin
      if (v[i]) begin
        idx = idx | bbcr_pkg::slot_idx_t'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [bbcr_pkg::OUT_SLOT_BITS-1:0] to_out_slot(
    input bbcr_pkg::slot_idx_t s);
    logic [31:0] wide;
    wide = 32'(s);
    return wide[bbcr_pkg::OUT_SLOT_BITS-1:0];
  endfunction

  // request
  logic [bbcr_pkg::OP_BITS-1:0]          req_op_r;
  logic [bbcr_pkg::TABLE_ID_BITS-1:0]    req_tid_r;
  logic [bbcr_pkg::BLOCK_INDEX_BITS-1:0] req_blk_r;
  logic                                  req_fresh_r;

  // slot state
  bbcr_pkg::slot_vec_t valid_r, valid_nxt;
  bbcr_pkg::slot_vec_t acc_r, acc_nxt;
  logic [bbcr_pkg::TABLE_ID_BITS-1:0]    tag_table_r [bbcr_pkg::SLOTS];
  logic [bbcr_pkg::BLOCK_INDEX_BITS-1:0] tag_block_r [bbcr_pkg::SLOTS];

  // lookup / select results
  bbcr_pkg::slot_vec_t hit_vec_r, tmatch_vec_r;
  bbcr_pkg::slot_vec_t hit_cmp, tm_cmp;
  logic                hit_any_r;
  bbcr_pkg::slot_idx_t hit_slot_r;
  bbcr_pkg::slot_idx_t vict_slot_r;
  logic                vict_full_r;
  bbcr_pkg::slot_vec_t acc_sweep_r;

  // clear walk
  bbcr_pkg::slot_vec_t pending_r;
  bbcr_pkg::slot_idx_t clr_slot_r;
  logic                clr_last_r;

  bbcr_pkg::slot_vec_t hit_one, empty_one, acc_one, sweep_below, vict_one;
  bbcr_pkg::slot_vec_t pick_one, pend_rest;
  bbcr_pkg::slot_idx_t vict_idx, pick_idx;

  // tag store for addressed reads
  logic                              ram_we, ram_re;
  bbcr_pkg::slot_idx_t               ram_raddr;
  logic [bbcr_pkg::TAG_BITS-1:0]     ram_wdata, ram_rdata;
  logic [bbcr_pkg::TABLE_ID_BITS-1:0]    rd_table;
  logic [bbcr_pkg::BLOCK_INDEX_BITS-1:0] rd_block;

  // result register
  logic                                  out_valid_r;
  logic                                  out_hit_r;
  logic [bbcr_pkg::OUT_SLOT_BITS-1:0]    out_slot_r;
  logic                                  out_wbv_r;
  logic [bbcr_pkg::TABLE_ID_BITS-1:0]    out_wbt_r;
  logic [bbcr_pkg::BLOCK_INDEX_BITS-1:0] out_wbb_r;
  logic [bbcr_pkg::FILL_BITS-1:0]        out_fill_r;
  logic                                  out_last_r;
  logic                                  out_load;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r    <= in_operation;
      req_tid_r   <= in_table_id;
      req_blk_r   <= in_block_index;
      req_fresh_r <= in_fresh_block;
    end
  end

  // parallel tag compare, one comparator per slot
  always_comb begin
    for (int i = 0; i < bbcr_pkg::SLOTS; i++) begin
      tm_cmp[i]  = valid_r[i] && (tag_table_r[i] == req_tid_r);
      hit_cmp[i] = tm_cmp[i] && (tag_block_r[i] == req_blk_r);
    end
  end

  // victim: lowest empty slot, else first slot with accessed clear
  always_comb begin
    hit_one     = lowest_one(hit_vec_r);
    empty_one   = lowest_one(~valid_r);
    acc_one     = lowest_one(~acc_r);
    // all bits below the first clear one; all ones if every bit is set
    sweep_below = acc_one - bbcr_pkg::slot_vec_t'(1);
    vict_one    = (&valid_r) ? acc_one : empty_one;
    vict_idx    = onehot_index(vict_one);
    pick_one    = lowest_one(pending_r);
    pend_rest   = pending_r & ~pick_one;
    pick_idx    = onehot_index(pick_one);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (cmd.lookup && (req_op_r == bbcr_pkg::OP_CLEAR)) begin
      pending_r <= valid_r;
    end else if (cmd.clr_pick) begin
      pending_r <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_vec_r    <= hit_cmp;
      tmatch_vec_r <= tm_cmp;
    end
    if (cmd.select) begin
      hit_any_r   <= |hit_vec_r;
      hit_slot_r  <= onehot_index(hit_one);
      vict_slot_r <= vict_idx;
      vict_full_r <= &valid_r;
      acc_sweep_r <= acc_r & ~sweep_below;
    end
    if (cmd.clr_pick) begin
      clr_slot_r <= pick_idx;
      clr_last_r <= (pend_rest == '0);
    end
  end

  assign ram_re    = cmd.select || cmd.clr_pick;
  assign ram_raddr = cmd.select ? vict_idx : pick_idx;
  assign ram_we    = cmd.get_commit && !hit_any_r;
  assign ram_wdata = {req_tid_r, req_blk_r};
  assign rd_table  = ram_rdata[bbcr_pkg::TAG_BITS-1 -: bbcr_pkg::TABLE_ID_BITS];
  assign rd_block  = ram_rdata[bbcr_pkg::BLOCK_INDEX_BITS-1:0];

  bbcr_ram #(
    .WIDTH(bbcr_pkg::TAG_BITS),
    .DEPTH(bbcr_pkg::SLOTS)
  ) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(vict_slot_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ram_we) begin
      tag_table_r[vict_slot_r] <= req_tid_r;
      tag_block_r[vict_slot_r] <= req_blk_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    acc_nxt   = acc_r;
    if (cmd.get_commit) begin
      if (hit_any_r) begin
        acc_nxt[hit_slot_r] = 1'b1;
      end else begin
        valid_nxt[vict_slot_r] = 1'b1;
        acc_nxt = vict_full_r ? acc_sweep_r : acc_r;
        acc_nxt[vict_slot_r] = 1'b1;
      end
    end else if (cmd.zero_commit && (req_op_r == bbcr_pkg::OP_DROP)) begin
      valid_nxt = valid_r & ~tmatch_vec_r;
      acc_nxt   = acc_r & ~tmatch_vec_r;
    end else if (cmd.clr_commit && clr_last_r) begin
      valid_nxt = '0;
      acc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      acc_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      acc_r   <= acc_nxt;
    end
  end

  assign out_load = cmd.get_commit || cmd.zero_commit || cmd.clr_commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.get_commit) begin
      out_hit_r  <= hit_any_r;
      out_slot_r <= to_out_slot(hit_any_r ? hit_slot_r : vict_slot_r);
      out_wbv_r  <= !hit_any_r && vict_full_r;
      out_wbt_r  <= (!hit_any_r && vict_full_r) ? rd_table : '0;
      out_wbb_r  <= (!hit_any_r && vict_full_r) ? rd_block : '0;
      out_fill_r <= hit_any_r ? bbcr_pkg::FILL_NONE :
                    (req_fresh_r ? bbcr_pkg::FILL_ZERO : bbcr_pkg::FILL_READ);
      out_last_r <= 1'b1;
    end else if (cmd.clr_commit) begin
      out_hit_r  <= 1'b0;
      out_slot_r <= to_out_slot(clr_slot_r);
      out_wbv_r  <= 1'b1;
      out_wbt_r  <= rd_table;
      out_wbb_r  <= rd_block;
      out_fill_r <= bbcr_pkg::FILL_NONE;
      out_last_r <= clr_last_r;
    end else if (cmd.zero_commit) begin
      out_hit_r  <= 1'b0;
      out_slot_r <= '0;
      out_wbv_r  <= 1'b0;
      out_wbt_r  <= '0;
      out_wbb_r  <= '0;
      out_fill_r <= bbcr_pkg::FILL_NONE;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_slot            = out_slot_r;
  assign out_writeback_valid = out_wbv_r;
  assign out_writeback_table = out_wbt_r;
  assign out_writeback_block = out_wbb_r;
  assign out_fill_action     = out_fill_r;
  assign out_last            = out_last_r;

  assign sts.req_op    = req_op_r;
  assign sts.any_valid = |valid_r;
  assign sts.clr_last  = clr_last_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // accessed bit only ever set on an occupied slot
  a_acc_in_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r & ~valid_r) == '0)
    else $error("accessed bit set on empty slot");

  // slots still to be written back are all occupied
  a_pending_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r & ~valid_r) == '0)
    else $error("pending write-back on empty slot");

  // final clear transfer empties the pool
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_commit && clr_last_r |=> valid_r == '0 && acc_r == '0)
    else $error("pool not empty after clear");

  // a hit never reports write-back or fill
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> !out_wbv_r && out_fill_r == bbcr_pkg::FILL_NONE)
    else $error("hit result carries write-back or fill");

  // results only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || !out_stall)
    else $error("result register overwritten");

endmodule

// ----- rtl/bbcr_ctrl.sv -----
// Request sequencer: steps each operation through lookup, selection and result transfers.
module bbcr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bbcr_pkg::bbcr_sts_t sts,
  output bbcr_pkg::bbcr_cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOOKUP   = 3'd1;
  localparam logic [2:0] S_SELECT   = 3'd2;
  localparam logic [2:0] S_GET      = 3'd3;
  localparam logic [2:0] S_ZERO     = 3'd4;
  localparam logic [2:0] S_CLR_PICK = 3'd5;
  localparam logic [2:0] S_CLR_EMIT = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (sts.req_op == bbcr_pkg::OP_GET) begin
          state_nxt = S_SELECT;
        end else if (sts.req_op == bbcr_pkg::OP_CLEAR && sts.any_valid) begin
          state_nxt = S_CLR_PICK;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = S_GET;
      end
      S_GET: begin
        if (sts.out_free) begin
          cmd.get_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_ZERO: begin
        if (sts.out_free) begin
          cmd.zero_commit = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_CLR_PICK: begin
        cmd.clr_pick = 1'b1;
        state_nxt    = S_CLR_EMIT;
      end
      S_CLR_EMIT: begin
        if (sts.out_free) begin
          cmd.clr_commit = 1'b1;
          state_nxt      = sts.clr_last ? S_IDLE : S_CLR_PICK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/block_buffer_clock_replacement.sv -----
// Buffer pool tag and clock replacement controller: one request at a time.
// Get: lookup, select, then result load; drop, clear of an empty pool and unused codes:
// lookup, then result load. A result load waits while the output register is held by a stall.
// Clear: a lookup, then per occupied slot a pick (with tag RAM read) and a commit.
// Synchronous active-low reset empties every slot at once; no clearing pass.
module block_buffer_clock_replacement (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [bbcr_pkg::OP_BITS-1:0]          in_operation,
  input  logic [bbcr_pkg::TABLE_ID_BITS-1:0]    in_table_id,
  input  logic [bbcr_pkg::BLOCK_INDEX_BITS-1:0] in_block_index,
  input  logic                                  in_fresh_block,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_hit,
  output logic [bbcr_pkg::OUT_SLOT_BITS-1:0]    out_slot,
  output logic                                  out_writeback_valid,
  output logic [bbcr_pkg::TABLE_ID_BITS-1:0]    out_writeback_table,
  output logic [bbcr_pkg::BLOCK_INDEX_BITS-1:0] out_writeback_block,
  output logic [bbcr_pkg::FILL_BITS-1:0]        out_fill_action,
  output logic                                  out_last
);

  bbcr_pkg::bbcr_cmd_t cmd;
  bbcr_pkg::bbcr_sts_t sts;

  bbcr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  bbcr_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_table_id        (in_table_id),
    .in_block_index     (in_block_index),
    .in_fresh_block     (in_fresh_block),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_slot           (out_slot),
    .out_writeback_valid(out_writeback_valid),
    .out_writeback_table(out_writeback_table),
    .out_writeback_block(out_writeback_block),
    .out_fill_action    (out_fill_action),
    .out_last           (out_last)
  );

endmodule

// ----- bench/block_buffer_clock_replacement_tb.sv -----
// Self-checking bench for the buffer pool tag and clock replacement controller.
module block_buffer_clock_replacement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbcr_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 111;
  localparam int FORCED_CLEAR_AT = 105;
  localparam int REUSE_WINDOW    = 40;
  localparam int QUIET_FROM      = 200;
  localparam int QUIET_TO        = 700;
  localparam int DRAIN_CYCLES    = 40;
  localparam int LIMIT_CYCLES    = 400000;

  typedef struct {
    logic [OP_BITS-1:0]          operation;
    logic [TABLE_ID_BITS-1:0]    table_id;
    logic [BLOCK_INDEX_BITS-1:0] block_index;
    logic                        fresh_block;
  } pool_request_t;

  typedef struct {
    logic                        hit;
    logic [OUT_SLOT_BITS-1:0]    slot;
    logic                        wb_valid;
    logic [TABLE_ID_BITS-1:0]    wb_table;
    logic [BLOCK_INDEX_BITS-1:0] wb_block;
    logic [FILL_BITS-1:0]        fill;
    logic                        last;
  } pool_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [OP_BITS-1:0]          in_operation;
  logic [TABLE_ID_BITS-1:0]    in_table_id;
  logic [BLOCK_INDEX_BITS-1:0] in_block_index;
  logic                        in_fresh_block;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_hit;
  logic [OUT_SLOT_BITS-1:0]    out_slot;
  logic                        out_writeback_valid;
  logic [TABLE_ID_BITS-1:0]    out_writeback_table;
  logic [BLOCK_INDEX_BITS-1:0] out_writeback_block;
  logic [FILL_BITS-1:0]        out_fill_action;
  logic                        out_last;

  // shadow copy of the pool tags
  logic                        pool_valid    [SLOTS];
  logic [TABLE_ID_BITS-1:0]    pool_table    [SLOTS];
  logic [BLOCK_INDEX_BITS-1:0] pool_block    [SLOTS];
  logic                        pool_accessed [SLOTS];

  pool_request_t requests_to_send[$];
  pool_request_t request_on_port;
  pool_result_t  pool_responses_due[$];
  pool_result_t  response_due;

  int requests_total    = 0;
  int requests_accepted = 0;
  int mismatch_count    = 0;
  int cycle_count       = 0;

  block_buffer_clock_replacement u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_table_id         (in_table_id),
    .in_block_index      (in_block_index),
    .in_fresh_block      (in_fresh_block),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_slot            (out_slot),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_table (out_writeback_table),
    .out_writeback_block (out_writeback_block),
    .out_fill_action     (out_fill_action),
    .out_last            (out_last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void empty_pool();
    for (int i = 0; i < SLOTS; i++) begin
      pool_valid[i]    = 1'b0;
      pool_table[i]    = '0;
      pool_block[i]    = '0;
      pool_accessed[i] = 1'b0;
    end
  endfunction

  function automatic void predict_pool_request(pool_request_t req);
    pool_result_t res;
    int victim;
    int final_slot;
    res = '{default: '0};
    res.last = 1'b1;
    victim = -1;
    final_slot = -1;
    case (req.operation)
      OP_GET: begin
        for (int i = 0; i < SLOTS && victim < 0; i++) begin
          if (pool_valid[i] && pool_table[i] == req.table_id &&
              pool_block[i] == req.block_index) victim = i;
        end
        if (victim >= 0) begin
          pool_accessed[victim] = 1'b1;
          res.hit  = 1'b1;
          res.slot = OUT_SLOT_BITS'(victim);
        end else begin
          for (int i = 0; i < SLOTS && victim < 0; i++) begin
            if (!pool_valid[i]) victim = i;
          end
          // second chance: sweep from slot 0, clearing set bits on the way
          for (int i = 0; i < SLOTS && victim < 0; i++) begin
            if (!pool_accessed[i]) victim = i;
            else pool_accessed[i] = 1'b0;
          end
          if (victim < 0) victim = 0;
          if (pool_valid[victim]) begin
            res.wb_valid = 1'b1;
            res.wb_table = pool_table[victim];
            res.wb_block = pool_block[victim];
          end
          pool_valid[victim]    = 1'b1;
          pool_table[victim]    = req.table_id;
          pool_block[victim]    = req.block_index;
          pool_accessed[victim] = 1'b1;
          res.slot = OUT_SLOT_BITS'(victim);
          res.fill = req.fresh_block ? FILL_ZERO : FILL_READ;
        end
        pool_responses_due.push_back(res);
      end
      OP_DROP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (pool_valid[i] && pool_table[i] == req.table_id) begin
            pool_valid[i]    = 1'b0;
            pool_table[i]    = '0;
            pool_block[i]    = '0;
            pool_accessed[i] = 1'b0;
          end
        end
        pool_responses_due.push_back(res);
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (pool_valid[i]) final_slot = i;
        end
        if (final_slot < 0) begin
          pool_responses_due.push_back(res);
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (pool_valid[i]) begin
              res.slot     = OUT_SLOT_BITS'(i);
              res.wb_valid = 1'b1;
              res.wb_table = pool_table[i];
              res.wb_block = pool_block[i];
              res.last     = (i == final_slot);
              pool_responses_due.push_back(res);
            end
          end
        end
        empty_pool();
      end
      default: begin
        pool_responses_due.push_back(res);
      end
    endcase
  endfunction

  function automatic pool_request_t make_request(logic [OP_BITS-1:0] op,
                                                 logic [TABLE_ID_BITS-1:0] tid,
                                                 logic [BLOCK_INDEX_BITS-1:0] blk,
                                                 logic fresh);
    pool_request_t req;
    req.operation   = op;
    req.table_id    = tid;
    req.block_index = blk;
    req.fresh_block = fresh;
    return req;
  endfunction

  // mostly a dozen small table ids so drops hit several slots, extremes now and then
  function automatic pool_request_t random_new_get();
    pool_request_t req;
    int unsigned pick;
    req.operation = OP_GET;
    pick = $urandom_range(0, 9);
    if (pick < 7) req.table_id = TABLE_ID_BITS'($urandom_range(1, 12));
    else if (pick == 7) req.table_id = '0;
    else if (pick == 8) req.table_id = '1;
    else req.table_id = TABLE_ID_BITS'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 6) req.block_index = BLOCK_INDEX_BITS'($urandom_range(0, 255));
    else if (pick == 6) req.block_index = '0;
    else if (pick == 7) req.block_index = '1;
    else req.block_index = BLOCK_INDEX_BITS'($urandom);
    req.fresh_block = 1'($urandom_range(0, 1));
    return req;
  endfunction

  function automatic bit idle_now();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 36;
  endfunction

  function automatic void compare_field(string field_name, logic [31:0] want,
                                        logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field_name, want, got);
      mismatch_count++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_pool_request(request_on_port);
        requests_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (requests_to_send.size() > 0 && !idle_now()) begin
          request_on_port = requests_to_send.pop_front();
          in_valid       <= 1'b1;
          in_operation   <= request_on_port.operation;
          in_table_id    <= request_on_port.table_id;
          in_block_index <= request_on_port.block_index;
          in_fresh_block <= request_on_port.fresh_block;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pool_responses_due.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected, expected none, actual slot 0x%0h",
                   $time, out_slot);
          mismatch_count++;
        end else begin
          response_due = pool_responses_due.pop_front();
          compare_field("hit", 32'(response_due.hit), 32'(out_hit));
          compare_field("slot", 32'(response_due.slot), 32'(out_slot));
          compare_field("writeback_valid", 32'(response_due.wb_valid),
                        32'(out_writeback_valid));
          compare_field("writeback_table", 32'(response_due.wb_table),
                        32'(out_writeback_table));
          compare_field("writeback_block", 32'(response_due.wb_block),
                        32'(out_writeback_block));
          compare_field("fill_action", 32'(response_due.fill), 32'(out_fill_action));
          compare_field("last", 32'(response_due.last), 32'(out_last));
        end
      end
      out_stall <= idle_now();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    pool_request_t req;
    pool_request_t issued_gets[$];
    int unsigned choice;
    int lo;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_GET;
    in_table_id    = '0;
    in_block_index = '0;
    in_fresh_block = 1'b0;
    out_stall      = 1'b0;
    empty_pool();

    // directed: empty clear, unused code, hits, drops with and without matches
    requests_to_send.push_back(make_request(OP_CLEAR, '0, '0, 1'b0));
    requests_to_send.push_back(make_request(OP_UNUSED, '1, '1, 1'b1));
    requests_to_send.push_back(make_request(OP_GET, '0, '0, 1'b0));
    requests_to_send.push_back(make_request(OP_GET, '1, '1, 1'b1));
    requests_to_send.push_back(make_request(OP_GET, '0, '0, 1'b0));
    requests_to_send.push_back(make_request(OP_DROP, '0, '1, 1'b1));
    requests_to_send.push_back(make_request(OP_GET, '0, '0, 1'b1));
    requests_to_send.push_back(make_request(OP_DROP, 16'h1234, '0, 1'b0));
    requests_to_send.push_back(make_request(OP_GET, '0, '1, 1'b0));
    requests_to_send.push_back(make_request(OP_GET, '1, '0, 1'b1));
    requests_to_send.push_back(make_request(OP_GET, '1, '1, 1'b0));
    requests_to_send.push_back(make_request(OP_UNUSED, '0, '0, 1'b0));
    requests_to_send.push_back(make_request(OP_DROP, '1, '0, 1'b0));
    requests_to_send.push_back(make_request(OP_GET, 16'h5555, 24'hAAAAAA, 1'b0));
    requests_to_send.push_back(make_request(OP_GET, 16'hAAAA, 24'h555555, 1'b1));
    requests_to_send.push_back(make_request(OP_CLEAR, '1, '1, 1'b1));
    requests_to_send.push_back(make_request(OP_GET, '0, '0, 1'b0));
    requests_to_send.push_back(make_request(OP_CLEAR, '0, '0, 1'b0));
    requests_to_send.push_back(make_request(OP_DROP, '0, '0, 1'b0));

    // random: mostly new blocks so the pool fills and the sweep runs
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      choice = $urandom_range(0, 99);
      if (n == FORCED_CLEAR_AT || choice < 1) begin
        req = make_request(OP_CLEAR, TABLE_ID_BITS'($urandom),
                           BLOCK_INDEX_BITS'($urandom), 1'($urandom));
      end else if (choice < 3) begin
        req = make_request(OP_UNUSED, TABLE_ID_BITS'($urandom),
                           BLOCK_INDEX_BITS'($urandom), 1'($urandom));
      end else if (choice < 7) begin
        req = random_new_get();
        if (issued_gets.size() > 0)
          req.table_id = issued_gets[$urandom_range(0, issued_gets.size() - 1)].table_id;
        req.operation = OP_DROP;
      end else if (choice < 22 && issued_gets.size() > 0) begin
        lo = (issued_gets.size() > REUSE_WINDOW) ? issued_gets.size() - REUSE_WINDOW : 0;
        req = issued_gets[$urandom_range(lo, issued_gets.size() - 1)];
        req.fresh_block = 1'($urandom_range(0, 1));
      end else begin
        req = random_new_get();
        issued_gets.push_back(req);
      end
      requests_to_send.push_back(req);
    end
    requests_total = requests_to_send.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_accepted < requests_total || pool_responses_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pool_responses_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
